FILE: rtl/core/slcs_pkg.sv
// Package with shared types, constants and the sigmoid table of the scorer.
`default_nettype none
package slcs_pkg;

   localparam int MaxClassesDefault  = 16;
   localparam int MaxFeaturesDefault = 4095;

   localparam int AccWidth  = 48;
   localparam int SigWidth  = 17;
   localparam int ProbWidth = 16;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NUM_CLASSES    = 2'd0;
   localparam logic [1:0] CSR_NUM_FEATURES   = 2'd1;
   localparam logic [1:0] CSR_BIAS_VALUE     = 2'd2;
   localparam logic [1:0] CSR_CRAMMER_SINGER = 2'd3;

   // Input item kinds.
   localparam logic KIND_WEIGHT  = 1'b0;
   localparam logic KIND_FEATURE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WREAD,
      ST_MAC,
      ST_BREAD,
      ST_BMAC,
      ST_SIG,
      ST_SUM,
      ST_DIV,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_item;    // capture the accepted feature transaction
      logic wr_weight;    // write the weight store
      logic rd_row;       // issue a weight read for the current class
      logic rd_bias;      // issue a bias-row weight read
      logic mac_en;       // accumulate the product of the read weight
      logic mul_en;       // reserved; the datapath does not use it
      logic sig_en;       // compute sigmoid of current class
      logic sum_en;       // add current sigmoid into the sum
      logic div_start;    // start the divider for current class
      logic out_load;     // load output register
      logic out_binary;   // output uses the two-class rule
      logic clear_en;     // clear current accumulator
      logic cls_reset;    // class counter to zero
      logic cls_inc;      // class counter increment
      logic sum_clear;    // zero the sigmoid sum
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic cls_last;     // class counter is at the last class in use
      logic div_done;     // divider finished
      logic feat_ok;      // captured feature index is in range
      logic item_last;    // captured feature closes the vector
      logic bias_on;      // bias value is positive
   } status_type;

   localparam logic [16:0] SIG_TAB [17] = '{
      17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
      17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
      17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
   };

   // Sigmoid of a Q32.16 accumulator as Q1.16 in 0..65536.
   function automatic logic [16:0] sigmoid_q16(input logic signed [47:0] x);
      logic        neg;
      logic [47:0] a;
      logic [3:0]  idx;
      logic [14:0] frac;
      logic [16:0] base;
      logic [16:0] dlt;
      logic [31:0] prod;
      logic [16:0] s;
      neg  = x[47];
      a    = neg ? (~x + 48'd1) : x;
      idx  = a[18:15];
      frac = a[14:0];
      base = SIG_TAB[idx];
      dlt  = SIG_TAB[5'(idx) + 5'd1] - base;
      prod = 32'(dlt) * 32'(frac);
      if (a >= 48'd524288) begin
         s = SIG_TAB[16];
      end else begin
         s = base + 17'(prod >> 15);
      end
      return neg ? (17'd65536 - s) : s;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/slcs_ram.sv
// Generic RAM with one write port, one read port and registered read data.
`default_nettype none
module slcs_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/slcs_div.sv
// Restoring divider: 33-bit dividend over 21-bit divisor, one bit per cycle.
`default_nettype none
module slcs_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] dividend,
   input  wire logic [20:0] divisor,
   output logic             done,
   output logic [32:0]      quotient
);
   logic [32:0] quo_ff, quo_in;
   logic [21:0] rem_ff, rem_in;
   logic [20:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [21:0] trial;

   // One quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[20:0], quo_ff[32]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/core/slcs_ctrl.sv
// Controller state machine of the scorer.
`default_nettype none
module slcs_ctrl
   import slcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_kind,
   input  wire logic       binary,
   input  wire logic       rsp_stall,
   input  wire status_type sts,
   output logic            req_stall,
   output logic            rsp_valid,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_FEATURE) begin
               state_in = ST_WREAD;
            end
         end
         ST_WREAD: begin
            if (!sts.feat_ok) begin
               state_in = sts.item_last ? (sts.bias_on ? ST_BREAD : ST_SIG) : ST_IDLE;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (sts.cls_last) begin
               state_in = sts.item_last ? (sts.bias_on ? ST_BREAD : ST_SIG) : ST_IDLE;
            end else begin
               state_in = ST_WREAD;
            end
         end
         ST_BREAD: state_in = ST_BMAC;
         ST_BMAC:  state_in = sts.cls_last ? ST_SIG : ST_BREAD;
         ST_SIG:   state_in = sts.cls_last ? (binary ? ST_EMIT : ST_SUM) : ST_SIG;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   state_in = sts.div_done ? ST_EMIT : ST_DIV;
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (sts.cls_last) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = binary ? ST_EMIT : ST_DIV;
               end
            end
         end
         ST_CLEAR: state_in = sts.cls_last ? ST_IDLE : ST_CLEAR;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.out_binary = binary;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_item = accept && req_kind == KIND_FEATURE;
            cmd.wr_weight = accept && req_kind == KIND_WEIGHT;
            cmd.cls_reset = 1'b1;
         end
         ST_WREAD: begin
            cmd.rd_row = sts.feat_ok;
            cmd.cls_reset = !sts.feat_ok;
         end
         ST_MAC: begin
            cmd.mac_en    = 1'b1;
            cmd.cls_inc   = !sts.cls_last;
            cmd.cls_reset = sts.cls_last;
         end
         ST_BREAD: cmd.rd_bias = 1'b1;
         ST_BMAC: begin
            cmd.mac_en    = 1'b1;
            cmd.cls_inc   = !sts.cls_last;
            cmd.cls_reset = sts.cls_last;
         end
         ST_SIG: begin
            cmd.sig_en    = 1'b1;
            cmd.sum_en    = 1'b1;
            cmd.cls_inc   = !sts.cls_last;
            cmd.cls_reset = sts.cls_last;
         end
         ST_SUM: cmd.div_start = 1'b1;
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               cmd.cls_inc   = !sts.cls_last;
               cmd.cls_reset = sts.cls_last;
               cmd.div_start = !sts.cls_last && !binary;
            end
         end
         ST_CLEAR: begin
            cmd.clear_en  = 1'b1;
            cmd.cls_inc   = !sts.cls_last;
            cmd.cls_reset = sts.cls_last;
            cmd.sum_clear = sts.cls_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // Items are taken only while idle.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> state_ff == ST_IDLE) else $error("accept out of idle");
   // A result is loaded only in the emit state.
   a_load_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> state_ff == ST_EMIT) else $error("output load out of emit");
   // A stalled result is not overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.out_load) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/slcs_dp.sv
// Datapath of the scorer: weight store, accumulators, sigmoid, divider, output register.
`default_nettype none
module slcs_dp
   import slcs_pkg::*;
#(
   parameter int MaxClasses  = MaxClassesDefault,
   parameter int MaxFeatures = MaxFeaturesDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              sts,
   input  wire logic [12:0]        req_feature_index,
   input  wire logic [3:0]         req_class_column,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_last,
   input  wire logic [4:0]         cfg_num_classes,
   input  wire logic [11:0]        cfg_num_features,
   input  wire logic signed [31:0] cfg_bias_value,
   output logic                    binary,
   output logic [3:0]              rsp_class_number,
   output logic [15:0]             rsp_probability,
   output logic                    rsp_last_class
);
   localparam int ClsBits  = $clog2(MaxClasses);
   localparam int RowBits  = $clog2(MaxFeatures + 1);
   localparam int AddrBits = RowBits + ClsBits;
   localparam int Depth    = 1 << AddrBits;
   localparam int NcBits   = $clog2(MaxClasses + 1);
   localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

   logic [ClsBits-1:0]      cls_ff, cls_in;
   logic [RowBits-1:0]      row_ff;
   logic signed [31:0]      val_ff;
   logic                    last_ff;
   logic                    ok_ff;
   logic                    bias_sel_ff;
   logic signed [AccWidth-1:0] acc_ff [MaxClasses];
   logic [SigWidth-1:0]     sig_ff [MaxClasses];
   logic [20:0]             sum_ff;
   logic [3:0]              oc_ff;
   logic [15:0]             op_ff;
   logic                    ol_ff;
   logic [NcBits-1:0]       nc;
   logic [31:0]             rd_data;
   logic                    wr_ok;
   logic [AddrBits-1:0]     wr_addr, rd_addr;
   logic [RowBits-1:0]      rd_row;
   logic signed [63:0]      prod;
   logic signed [AccWidth:0] acc_sum;
   logic signed [47:0]      term;
   logic                    div_done;
   logic [32:0]             quotient;
   logic [16:0]             sig_cur;
   logic [17:0]             pbin;
   logic                    fidx_ok;

   // Effective class count clamped to 2..MaxClasses.
   always_comb begin
      if (cfg_num_classes < 5'd2) begin
         nc = NcBits'(2);
      end else if (32'(cfg_num_classes) > MaxClasses) begin
         nc = NcBits'(MaxClasses);
      end else begin
         nc = NcBits'(cfg_num_classes);
      end
   end
   assign binary = (nc == NcBits'(2));

   // Weight write address.
   assign wr_ok = req_feature_index >= 13'd1 &&
                  32'(req_feature_index) <= MaxFeatures + 1 &&
                  32'(req_class_column) < MaxClasses;
   assign wr_addr = {RowBits'(req_feature_index - 13'd1), ClsBits'(req_class_column)};
   assign rd_row  = cmd.rd_bias ? RowBits'(MaxFeatures) : row_ff;
   assign rd_addr = {rd_row, cls_ff};

   slcs_ram #(.Width(32), .Depth(Depth)) u_wstore (
      .clock  (clock),
      .wr_en  (cmd.wr_weight && wr_ok),
      .wr_addr(wr_addr),
      .wr_data(req_value),
      .rd_en  (cmd.rd_row || cmd.rd_bias),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Feature capture.
   assign fidx_ok = req_feature_index >= 13'd1 &&
                    req_feature_index <= {1'b0, cfg_num_features} &&
                    32'(req_feature_index) <= MaxFeatures;
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         row_ff  <= RowBits'(req_feature_index - 13'd1);
         val_ff  <= req_value;
         last_ff <= req_last;
         ok_ff   <= fidx_ok;
      end
   end

   // Class counter.
   always_comb begin
      cls_in = cls_ff;
      if (cmd.cls_reset) begin
         cls_in = '0;
      end else if (cmd.cls_inc) begin
         cls_in = cls_ff + ClsBits'(1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff <= '0;
      end else begin
         cls_ff <= cls_in;
      end
   end

   // The bias value is the multiplicand in the cycle after a bias-row read.
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_sel_ff <= 1'b0;
      end else begin
         bias_sel_ff <= cmd.rd_bias;
      end
   end

   // Multiply-accumulate with floor shift and saturation.
   assign prod    = $signed(rd_data) * (bias_sel_ff ? cfg_bias_value : val_ff);
   assign term    = 48'(prod >>> 16);
   assign acc_sum = {acc_ff[cls_ff][AccWidth-1], acc_ff[cls_ff]} + {term[47], term};

   assign sig_cur = sigmoid_q16(acc_ff[cls_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxClasses; i++) begin
            acc_ff[i] <= '0;
            sig_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else begin
         if (cmd.mac_en) begin
            if (acc_sum > $signed({AccMax[AccWidth-1], AccMax})) begin
               acc_ff[cls_ff] <= AccMax;
            end else if (acc_sum < $signed({AccMin[AccWidth-1], AccMin})) begin
               acc_ff[cls_ff] <= AccMin;
            end else begin
               acc_ff[cls_ff] <= acc_sum[AccWidth-1:0];
            end
         end
         if (cmd.clear_en) begin
            acc_ff[cls_ff] <= '0;
         end
         if (cmd.sig_en) begin
            sig_ff[cls_ff] <= sig_cur;
         end
         if (cmd.sum_clear) begin
            sum_ff <= '0;
         end else if (cmd.sum_en) begin
            sum_ff <= sum_ff + 21'(sig_cur);
         end
      end
   end

   // Divider for multiclass normalization; sum is never zero.
   slcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend({sig_ff[cls_in], 16'd0}),
      .divisor (sum_ff),
      .done    (div_done),
      .quotient(quotient)
   );

   // Output register.
   assign pbin = (cls_ff == '0) ? {1'b0, sig_ff[0]} : (18'd65536 - {1'b0, sig_ff[0]});
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         oc_ff <= 4'(cls_ff);
         ol_ff <= (NcBits'(cls_ff) + NcBits'(1) == nc);
         if (cmd.out_binary) begin
            op_ff <= (pbin > 18'd65535) ? 16'hFFFF : pbin[15:0];
         end else begin
            op_ff <= (quotient > 33'd65535) ? 16'hFFFF : quotient[15:0];
         end
      end
   end

   assign rsp_class_number = oc_ff;
   assign rsp_probability  = op_ff;
   assign rsp_last_class   = ol_ff;

   assign sts.cls_last  = (NcBits'(cls_ff) + NcBits'(1) == nc);
   assign sts.div_done  = div_done;
   assign sts.feat_ok   = ok_ff;
   assign sts.item_last = last_ff;
   assign sts.bias_on   = (cfg_bias_value > 32'sd0);
endmodule
`default_nettype wire

FILE: rtl/core/sparse_linear_classifier_scorer_core.sv
// Top level of the sparse linear classifier scorer.
// Usage:
//   Input transactions on req_* either write one weight (kind 0) or carry one
//   feature of a vector (kind 1). The weight store has one read port, so each
//   class of a feature needs one weight read and then one multiply-accumulate.
//   On the feature with last set, a positive bias adds a bias-row read and
//   multiply-accumulate per class, then the sigmoid is taken class by class.
//   Two classes emit two results directly; more classes pass each class
//   through the shared one-bit-per-cycle divider. Results leave on rsp_* one
//   per class; a stalled result holds and the block waits. After the last
//   result the accumulators clear one class at a time. Configuration on csr_*
//   is written on each edge with csr_write_enable set; the user must write it
//   only while the block is idle, which the block does not enforce. Reset is
//   synchronous: configuration registers, controller state and accumulators
//   return to defaults; the weight store keeps unknown contents.
`default_nettype none
module sparse_linear_classifier_scorer_core
   import slcs_pkg::*;
#(
   parameter int MaxClasses  = MaxClassesDefault,
   parameter int MaxFeatures = MaxFeaturesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [12:0] req_feature_index,
   input  wire logic [3:0]  req_class_column,
   input  wire logic [31:0] req_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_class_number,
   output logic [15:0]      rsp_probability,
   output logic             rsp_last_class,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   logic [4:0]         num_classes_ff;
   logic [11:0]        num_features_ff;
   logic signed [31:0] bias_value_ff;
   logic               crammer_singer_ff;
   cmd_type            cmd;
   status_type         sts;
   logic               binary;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff    <= 5'd2;
         num_features_ff   <= 12'd4095;
         bias_value_ff     <= -32'sd65536;
         crammer_singer_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NUM_CLASSES:    num_classes_ff    <= csr_data[4:0];
            CSR_NUM_FEATURES:   num_features_ff   <= csr_data[11:0];
            CSR_BIAS_VALUE:     bias_value_ff     <= csr_data;
            CSR_CRAMMER_SINGER: crammer_singer_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   slcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_kind (req_kind),
      .binary   (binary),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .cmd      (cmd)
   );

   slcs_dp #(.MaxClasses(MaxClasses), .MaxFeatures(MaxFeatures)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_feature_index(req_feature_index),
      .req_class_column (req_class_column),
      .req_value        (req_value),
      .req_last         (req_last),
      .cfg_num_classes  (num_classes_ff),
      .cfg_num_features (num_features_ff),
      .cfg_bias_value   (bias_value_ff),
      .binary           (binary),
      .rsp_class_number (rsp_class_number),
      .rsp_probability  (rsp_probability),
      .rsp_last_class   (rsp_last_class)
   );
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the sparse linear classifier scorer core.
`timescale 1ns / 100ps
module tb_top;
   import slcs_pkg::*;

   localparam int WatchLimit  = 4000;
   localparam int DrainCycles = 80;
   localparam int PhaseItems  = 30;
   localparam longint AccMax  = 64'sh7FFF_FFFF_FFFF;
   localparam longint AccMin  = -AccMax - 1;

   typedef struct {
      logic [3:0]  cls;
      logic [15:0] prob;
      logic        lastc;
   } class_prob_t;

   typedef struct {
      logic        kind;
      logic [12:0] idx;
      logic [3:0]  col;
      logic [31:0] val;
      logic        last;
      logic        typed;
      logic [15:0] p0;
      logic [15:0] p1;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [12:0] req_feature_index = '0;
   logic [3:0]  req_class_column = '0;
   logic [31:0] req_value = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_class_number;
   logic [15:0] rsp_probability;
   logic        rsp_last_class;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Scorer state kept by the testbench.
   logic [31:0] weight_rows [0:4095][0:15];
   longint      class_sums [16];
   int unsigned cfg_classes;
   int unsigned cfg_features;
   longint      cfg_bias;
   bit          cfg_crammer;
   int unsigned logistic_tab [17] = '{
      32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
      64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
   };

   class_prob_t expected_probs [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          vectors_scored = 0;
   int          idle_cycles = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;

   int          phase_classes [6] = '{16, 3, 31, 1, 5, 7};
   int          phase_features [6] = '{4095, 1, 20, 4095, 8, 4095};
   logic [31:0] phase_bias [6] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                   32'h8000_0000, 32'h0000_8000, 32'hFFFF_FFFF};
   bit          phase_crammer [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   sparse_linear_classifier_scorer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_feature_index(req_feature_index), .req_class_column(req_class_column),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_class_number(rsp_class_number), .rsp_probability(rsp_probability),
      .rsp_last_class(rsp_last_class),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Multiply-accumulate with floor rounding and 48-bit saturation.
   function automatic longint mac_sat(longint sum, logic [31:0] w, logic [31:0] x);
      longint prod;
      longint s;
      prod = longint'($signed(w)) * longint'($signed(x));
      s = sum + (prod >>> 16);
      if (s > AccMax) s = AccMax;
      if (s < AccMin) s = AccMin;
      return s;
   endfunction

   // Table-driven logistic function, Q32.16 in and Q16.16 out.
   function automatic int unsigned logistic_q16(longint x);
      longint      a;
      int unsigned k;
      int unsigned frac;
      int unsigned s;
      a = (x < 0) ? -x : x;
      if (a >= 524288) begin
         s = logistic_tab[16];
      end else begin
         k = int'(a >> 15);
         frac = int'(a & 32767);
         s = logistic_tab[k] + (((logistic_tab[k + 1] - logistic_tab[k]) * frac) >> 15);
      end
      return (x < 0) ? 65536 - s : s;
   endfunction

   function automatic logic [15:0] clamp_prob(longint p);
      return (p > 65535) ? 16'hFFFF : 16'(p);
   endfunction

   // Appends one expected class result at the tail of the queue.
   function automatic void queue_result(class_prob_t r);
      expected_probs.insert(expected_probs.size(), r);
   endfunction

   // Applies one accepted transaction and queues the class probabilities it yields.
   task automatic score_item(logic kind, logic [12:0] idx, logic [3:0] col,
                             logic [31:0] val, logic last);
      int unsigned nc;
      int unsigned sum;
      int unsigned sig [16];
      class_prob_t r;
      nc = cfg_classes;
      if (nc < 2) nc = 2;
      if (nc > 16) nc = 16;
      if (kind == KIND_WEIGHT) begin
         if (idx >= 1 && idx <= 4096) weight_rows[idx - 1][col] = val;
         return;
      end
      if (idx >= 1 && idx <= cfg_features && idx <= 4095) begin
         for (int c = 0; c < nc; c++)
            class_sums[c] = mac_sat(class_sums[c], weight_rows[idx - 1][c], val);
      end
      if (!last) return;
      if (cfg_bias > 0) begin
         for (int c = 0; c < nc; c++)
            class_sums[c] = mac_sat(class_sums[c], weight_rows[4095][c], 32'(cfg_bias));
      end
      sum = 0;
      for (int c = 0; c < nc; c++) begin
         sig[c] = logistic_q16(class_sums[c]);
         sum += sig[c];
      end
      if (nc == 2) begin
         r = '{4'd0, clamp_prob(sig[0]), 1'b0};
         queue_result(r);
         r = '{4'd1, clamp_prob(65536 - sig[0]), 1'b1};
         queue_result(r);
      end else begin
         for (int c = 0; c < nc; c++) begin
            r.cls = 4'(c);
            r.prob = (sum == 0) ? 16'd0 : clamp_prob((longint'(sig[c]) << 16) / sum);
            r.lastc = (c + 1 == nc);
            queue_result(r);
         end
      end
      for (int c = 0; c < 16; c++) class_sums[c] = 0;
      vectors_scored++;
   endtask

   // Presents one transaction, waits for it to be taken, then updates the predictor.
   task automatic send_item(logic kind, logic [12:0] idx, logic [3:0] col,
                            logic [31:0] val, logic last);
      bit ok;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_feature_index <= idx;
      req_class_column <= col;
      req_value <= val;
      req_last <= last;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      score_item(kind, idx, col, val, last);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Waits until every expected result is out and the block has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_probs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] i, logic [31:0] d);
      csr_write_enable <= 1'b1;
      csr_index <= i;
      csr_data <= d;
      @(posedge clock);
      case (i)
         CSR_NUM_CLASSES:    cfg_classes = d[4:0];
         CSR_NUM_FEATURES:   cfg_features = d[11:0];
         CSR_BIAS_VALUE:     cfg_bias = longint'($signed(d));
         CSR_CRAMMER_SINGER: cfg_crammer = d[0];
         default: ;
      endcase
   endtask

   // Mostly small Q16.16 values so that probabilities stay away from the rails.
   function automatic logic [31:0] rand_value();
      if ($urandom_range(0, 3) != 0)
         return 32'($urandom_range(0, 262143)) - 32'd131072;
      return $urandom;
   endfunction

   // A feature row whose weights have all been written.
   function automatic logic [12:0] loaded_row();
      int unsigned k;
      k = $urandom_range(0, 8);
      return (k < 8) ? 13'(k + 1) : 13'd4095;
   endfunction

   // A feature index that contributes nothing under the current settings.
   function automatic logic [12:0] dead_row();
      case ($urandom_range(0, 2))
         0: return 13'd0;
         1: return 13'($urandom_range(4096, 8191));
         default: return (cfg_features < 4095) ?
                         13'($urandom_range(cfg_features + 1, 4095)) : 13'd0;
      endcase
   endfunction

   // Random mix of scored vectors, weight updates and out-of-range features.
   task automatic random_items(int target);
      int sent;
      int len;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 9))
            0: begin
               if ($urandom_range(0, 4) != 0) begin
                  send_item(KIND_WEIGHT, ($urandom_range(0, 5) == 0) ? 13'd4096 : loaded_row(),
                            4'($urandom), rand_value(), 1'($urandom));
                  sent++;
               end else begin
                  send_item(KIND_WEIGHT, ($urandom_range(0, 1) == 0) ? 13'd0 :
                            13'($urandom_range(4097, 8191)), 4'($urandom), $urandom,
                            1'($urandom));
               end
               maybe_gap();
            end
            1: begin
               len = ($urandom_range(0, 2) == 0);
               send_item(KIND_FEATURE, dead_row(), 4'($urandom), $urandom, 1'(len));
               sent += len;
               maybe_gap();
            end
            default: begin
               len = $urandom_range(1, 5);
               for (int i = 0; i < len; i++) begin
                  send_item(KIND_FEATURE, ($urandom_range(0, 7) == 0) ? dead_row() :
                            loaded_row(), 4'($urandom), rand_value(), i == len - 1);
                  sent++;
                  maybe_gap();
               end
            end
         endcase
      end
   endtask

   // Result checking and the watchdog, sampled away from the driving edge.
   always @(negedge clock) begin : rsp_check
      class_prob_t e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_probs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: class %0d prob %0d last %0d",
                           rsp_class_number, rsp_probability, rsp_last_class);
            end else begin
               e = expected_probs.pop_front();
               if (e.cls !== rsp_class_number || e.prob !== rsp_probability ||
                   e.lastc !== rsp_last_class) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected class %0d prob %0d last %0d,",
                              e.cls, e.prob, e.lastc,
                              " got class %0d prob %0d last %0d",
                              rsp_class_number, rsp_probability, rsp_last_class);
               end
            end
         end
         if (idle_cycles >= WatchLimit) begin
            $display("watchdog: no transaction for %0d cycles", WatchLimit);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Random stall bursts on the result side.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      stim_row_t directed_rows [22] = '{
         '{KIND_FEATURE, 13'd0,    4'd0,  32'h0000_0000, 1'b1, 1'b1, 16'd32768, 16'd32768},
         '{KIND_WEIGHT,  13'd2,    4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd2,    4'd1,  32'h8000_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd2,    4'd9,  32'h7FFF_FFFF, 1'b1, 1'b1, 16'd65514, 16'd22},
         '{KIND_FEATURE, 13'd2,    4'd0,  32'h8000_0000, 1'b1, 1'b1, 16'd22,    16'd65514},
         '{KIND_WEIGHT,  13'd4095, 4'd0,  32'h0000_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd4095, 4'd1,  32'h0000_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd4095, 4'd15, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'd32768, 16'd32768},
         '{KIND_FEATURE, 13'd4096, 4'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 16'd32768, 16'd32768},
         '{KIND_FEATURE, 13'd8191, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd0,    4'd0,  32'h8000_0000, 1'b1, 1'b1, 16'd32768, 16'd32768},
         '{KIND_WEIGHT,  13'd0,    4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd8191, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd4097, 4'd7,  32'h1234_5678, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd4096, 4'd15, 32'h5555_5555, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd2,    4'd0,  32'h0001_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd2,    4'd1,  32'hFFFF_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd1,    4'd0,  32'h0001_0000, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd3,    4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd2,    4'd0,  32'h0002_8000, 1'b1, 1'b0, 16'd0,     16'd0},
         '{KIND_WEIGHT,  13'd1,    4'd15, 32'hAAAA_AAAA, 1'b0, 1'b0, 16'd0,     16'd0},
         '{KIND_FEATURE, 13'd1,    4'd15, 32'h0000_8000, 1'b1, 1'b0, 16'd0,     16'd0}
      };
      int first_row;

      cfg_classes = 2;
      cfg_features = 4095;
      cfg_bias = -65536;
      cfg_crammer = 1'b0;
      for (int c = 0; c < 16; c++) class_sums[c] = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every weight that a scored feature or the bias row can reach.
      for (int row = 1; row <= 10; row++) begin
         for (int c = 0; c < 16; c++)
            send_item(KIND_WEIGHT, (row <= 8) ? 13'(row) : 13'(4086 + row), 4'(c),
                      rand_value(), 1'b0);
      end
      maybe_gap();

      // Directed rows; typed rows carry a hand-computed two-class answer.
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].col,
                   directed_rows[i].val, directed_rows[i].last);
         if (directed_rows[i].typed) begin
            first_row = expected_probs.size() - 2;
            expected_probs[first_row].prob = directed_rows[i].p0;
            expected_probs[first_row + 1].prob = directed_rows[i].p1;
         end
         maybe_gap();
      end
      random_items(60);

      // Configuration phases, the last one without any idling.
      for (int p = 0; p < 6; p++) begin
         drain();
         if (p == 5) quiet = 1'b1;
         write_csr(CSR_NUM_CLASSES, 32'(phase_classes[p]));
         write_csr(CSR_NUM_FEATURES, 32'(phase_features[p]));
         write_csr(CSR_BIAS_VALUE, phase_bias[p]);
         write_csr(CSR_CRAMMER_SINGER, 32'(phase_crammer[p]));
         csr_write_enable <= 1'b0;
         random_items(PhaseItems);
         send_item(KIND_FEATURE, 13'd0, 4'd0, 32'd0, 1'b1);
      end
      drain();

      $display("Scored %0d vectors over 7 register settings; %0d class results checked.",
               vectors_scored, results_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/slcs_pkg.sv
rtl/core/slcs_ram.sv
rtl/core/slcs_div.sv
rtl/core/slcs_ctrl.sv
rtl/core/slcs_dp.sv
rtl/core/sparse_linear_classifier_scorer_core.sv
tb/tb_top.sv
